// ===== src/sms_pkg.sv =====
// ----------------------------------------------------------------------------
// sms_pkg
// Shared types and codes for the stack machine step block.
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_EXEC   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [2:0] TRAP_OK       = 3'd0;
  localparam logic [2:0] TRAP_OVERFLOW = 3'd1;
  localparam logic [2:0] TRAP_UNDERFLW = 3'd2;
  localparam logic [2:0] TRAP_ILLEGAL  = 3'd3;
  localparam logic [2:0] TRAP_BAD_IP   = 3'd4;
  localparam logic [2:0] TRAP_BAD_OPND = 3'd5;
  localparam logic [2:0] TRAP_DIV_ZERO = 3'd6;
  localparam logic [2:0] TRAP_PROG_FUL = 3'd7;

  localparam logic [3:0] K_PUSH  = 4'd0;
  localparam logic [3:0] K_ADD   = 4'd1;
  localparam logic [3:0] K_SUB   = 4'd2;
  localparam logic [3:0] K_MUL   = 4'd3;
  localparam logic [3:0] K_DIV   = 4'd4;
  localparam logic [3:0] K_DUP   = 4'd5;
  localparam logic [3:0] K_JMP   = 4'd6;
  localparam logic [3:0] K_CJMP  = 4'd7;
  localparam logic [3:0] K_EQ    = 4'd8;
  localparam logic [3:0] K_HALT  = 4'd9;
  localparam logic [3:0] K_PRINT = 4'd10;

  localparam int MD_STEPS = 64;

  typedef enum logic [3:0] {
    S_IDLE, S_APPEND, S_CLEAR, S_FETCH, S_DECODE, S_MD_WAIT, S_DUP_WR, S_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_LATCH, DP_APPEND, DP_CLEAR, DP_FETCH, DP_EXEC,
    DP_MD_COMMIT, DP_DUP_COMMIT, DP_LOAD_OUT
  } dp_op_t;

  typedef enum logic [1:0] {
    CLS_SIMPLE, CLS_MULDIV, CLS_DUP
  } inst_class_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic        ip_bad;
    logic [2:0]  dec_trap;
    inst_class_t dec_class;
    logic        md_done;
  } dp_status_t;

endpackage

// ===== src/sms_muldiv.sv =====
// ----------------------------------------------------------------------------
// sms_muldiv
// Iterative 64-bit multiplier (low half) and signed divider, one bit a cycle.
// ----------------------------------------------------------------------------
module sms_muldiv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        is_div,
  input  logic [63:0] opa,
  input  logic [63:0] opb,
  output logic        done,
  output logic [63:0] result
);
  import sms_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        div_r, div_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] y_r, y_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [64:0] shifted;
  logic [64:0] diff;

  assign shifted = {acc_r, x_r[63]};
  assign diff    = shifted - {1'b0, y_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 7'd0;
      div_nxt  = is_div;
      acc_nxt  = 64'd0;
      if (is_div) begin
        // Divide the magnitudes and fix the sign at the end.
        neg_nxt = opa[63] ^ opb[63];
        x_nxt   = opa[63] ? (64'd0 - opa) : opa;
        y_nxt   = opb[63] ? (64'd0 - opb) : opb;
      end else begin
        neg_nxt = 1'b0;
        x_nxt   = opa;
        y_nxt   = opb;
      end
    end else if (busy_r) begin
      if (div_r) begin
        if (!diff[64]) begin
          acc_nxt = diff[63:0];
          x_nxt   = {x_r[62:0], 1'b1};
        end else begin
          acc_nxt = shifted[63:0];
          x_nxt   = {x_r[62:0], 1'b0};
        end
      end else begin
        if (y_r[0]) begin
          acc_nxt = acc_r + x_r;
        end
        x_nxt = {x_r[62:0], 1'b0};
        y_nxt = {1'b0, y_r[63:1]};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'(MD_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    div_r <= div_nxt;
    neg_r <= neg_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
  end

  assign done   = done_r;
  assign result = div_r ? (neg_r ? (64'd0 - x_r) : x_r) : acc_r;

endmodule

// ===== src/sms_datapath.sv =====
// ----------------------------------------------------------------------------
// sms_datapath
// Program and stack memories, machine registers, decode checks and results.
// ----------------------------------------------------------------------------
module sms_datapath #(
  parameter int STACK_DEPTH   = 1024,
  parameter int PROGRAM_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sms_pkg::dp_cmd_t    cmd,
  output sms_pkg::dp_status_t sts,
  input  logic [3:0]          in_inst_kind,
  input  logic signed [63:0]  in_inst_operand,
  output logic [2:0]          out_trap_code,
  output logic signed [63:0]  out_next_ip,
  output logic [10:0]         out_depth_after,
  output logic signed [63:0]  out_top_word,
  output logic                out_top_present,
  output logic                out_is_halted,
  output logic                out_debug_print,
  output logic [10:0]         out_loaded_count
);
  import sms_pkg::*;

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SDW = $clog2(STACK_DEPTH + 1);
  localparam int PAW = $clog2(PROGRAM_DEPTH);
  localparam int PDW = $clog2(PROGRAM_DEPTH + 1);

  logic [63:0] stack_mem [STACK_DEPTH];
  logic [3:0]  prog_kind_mem [PROGRAM_DEPTH];
  logic [63:0] prog_opnd_mem [PROGRAM_DEPTH];

  logic [3:0]     inst_kind_r;
  logic [63:0]    inst_opnd_r;
  logic [2:0]     trap_r;
  logic           print_r;
  logic           halted_r;
  logic [63:0]    ip_r;
  logic [SDW-1:0] depth_r;
  logic [PDW-1:0] len_r;
  logic [63:0]    top_r;
  logic [63:0]    stack_rd_r;
  logic [3:0]     kind_rd_r;
  logic [63:0]    opnd_rd_r;

  logic [SAW-1:0] d_addr, d_m2_addr, dup_addr, st_raddr, st_waddr;
  logic           st_we, st_re;
  logic [63:0]    st_wdata;
  logic [63:0]    alu_res;
  logic [2:0]     dec_trap;
  inst_class_t    dec_class;
  logic           ip_bad;
  logic           md_start, md_done;
  logic [63:0]    md_res;
  logic           exec_ok;

  assign d_addr    = SAW'(depth_r);
  assign d_m2_addr = SAW'(depth_r - SDW'(2));
  assign dup_addr  = SAW'(depth_r - SDW'(1) - opnd_rd_r[SDW-1:0]);
  assign ip_bad    = ip_r[63] || (ip_r >= 64'(len_r));
  assign exec_ok   = (cmd.op == DP_EXEC) && (dec_trap == TRAP_OK);

  // Checks follow the fixed order: empty before full before operand range.
  always_comb begin
    dec_trap  = TRAP_OK;
    dec_class = CLS_SIMPLE;
    if (kind_rd_r > K_PRINT) begin
      dec_trap = TRAP_ILLEGAL;
    end else begin
      case (kind_rd_r)
        K_PUSH: begin
          if (depth_r >= SDW'(STACK_DEPTH)) dec_trap = TRAP_OVERFLOW;
        end
        K_ADD, K_SUB, K_EQ: begin
          if (depth_r < SDW'(2)) dec_trap = TRAP_UNDERFLW;
        end
        K_MUL, K_DIV: begin
          dec_class = CLS_MULDIV;
          if (depth_r < SDW'(2)) dec_trap = TRAP_UNDERFLW;
          else if (kind_rd_r == K_DIV && top_r == 64'd0) dec_trap = TRAP_DIV_ZERO;
        end
        K_DUP: begin
          dec_class = CLS_DUP;
          if (depth_r == SDW'(0)) dec_trap = TRAP_UNDERFLW;
          else if (depth_r >= SDW'(STACK_DEPTH)) dec_trap = TRAP_OVERFLOW;
          else if (!opnd_rd_r[63] && opnd_rd_r >= 64'(depth_r)) dec_trap = TRAP_UNDERFLW;
          else if (opnd_rd_r[63]) dec_trap = TRAP_BAD_OPND;
        end
        K_CJMP, K_PRINT: begin
          if (depth_r == SDW'(0)) dec_trap = TRAP_UNDERFLW;
        end
        default: dec_trap = TRAP_OK;
      endcase
    end
  end

  always_comb begin
    case (kind_rd_r)
      K_ADD:   alu_res = stack_rd_r + top_r;
      K_SUB:   alu_res = stack_rd_r - top_r;
      default: alu_res = {63'd0, stack_rd_r == top_r};
    endcase
  end

  // Stack memory port control.
  always_comb begin
    st_re    = 1'b0;
    st_raddr = d_m2_addr;
    st_we    = 1'b0;
    st_waddr = d_addr;
    st_wdata = opnd_rd_r;
    case (cmd.op)
      DP_FETCH: st_re = 1'b1;
      DP_EXEC: begin
        st_re    = 1'b1;
        st_raddr = dup_addr;
        if (dec_trap == TRAP_OK) begin
          if (kind_rd_r == K_PUSH) begin
            st_we = 1'b1;
          end else if (kind_rd_r == K_ADD || kind_rd_r == K_SUB || kind_rd_r == K_EQ) begin
            st_we    = 1'b1;
            st_waddr = d_m2_addr;
            st_wdata = alu_res;
          end
        end
      end
      DP_MD_COMMIT: begin
        st_we    = 1'b1;
        st_waddr = d_m2_addr;
        st_wdata = md_res;
      end
      DP_DUP_COMMIT: begin
        st_we    = 1'b1;
        st_wdata = stack_rd_r;
      end
      default: st_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) stack_mem[st_waddr] <= st_wdata;
    if (st_re) stack_rd_r <= stack_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_APPEND && len_r < PDW'(PROGRAM_DEPTH)) begin
      prog_kind_mem[PAW'(len_r)] <= inst_kind_r;
      prog_opnd_mem[PAW'(len_r)] <= inst_opnd_r;
    end
    if (cmd.op == DP_FETCH) begin
      kind_rd_r <= prog_kind_mem[ip_r[PAW-1:0]];
      opnd_rd_r <= prog_opnd_mem[ip_r[PAW-1:0]];
    end
  end

  assign md_start = exec_ok && (dec_class == CLS_MULDIV);

  sms_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (md_start),
    .is_div (kind_rd_r == K_DIV),
    .opa    (stack_rd_r),
    .opb    (top_r),
    .done   (md_done),
    .result (md_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r <= 1'b0;
      ip_r     <= 64'd0;
      depth_r  <= '0;
      len_r    <= '0;
      trap_r   <= TRAP_OK;
      print_r  <= 1'b0;
    end else begin
      case (cmd.op)
        DP_LATCH: begin
          trap_r  <= TRAP_OK;
          print_r <= 1'b0;
        end
        DP_APPEND: begin
          if (len_r >= PDW'(PROGRAM_DEPTH)) trap_r <= TRAP_PROG_FUL;
          else len_r <= len_r + PDW'(1);
        end
        DP_CLEAR: len_r <= '0;
        DP_FETCH: begin
          if (ip_bad) trap_r <= TRAP_BAD_IP;
        end
        DP_EXEC: begin
          trap_r <= dec_trap;
          if (dec_trap == TRAP_OK) begin
            case (kind_rd_r)
              K_PUSH: begin
                depth_r <= depth_r + SDW'(1);
                ip_r    <= ip_r + 64'd1;
              end
              K_ADD, K_SUB, K_EQ: begin
                depth_r <= depth_r - SDW'(1);
                ip_r    <= ip_r + 64'd1;
              end
              K_JMP: ip_r <= opnd_rd_r;
              K_CJMP: begin
                if (top_r != 64'd0) begin
                  depth_r <= depth_r - SDW'(1);
                  ip_r    <= opnd_rd_r;
                end else begin
                  ip_r <= ip_r + 64'd1;
                end
              end
              K_HALT: halted_r <= 1'b1;
              K_PRINT: begin
                print_r <= 1'b1;
                ip_r    <= ip_r + 64'd1;
              end
              default: ip_r <= ip_r;
            endcase
          end
        end
        DP_MD_COMMIT: begin
          depth_r <= depth_r - SDW'(1);
          ip_r    <= ip_r + 64'd1;
        end
        DP_DUP_COMMIT: begin
          depth_r <= depth_r + SDW'(1);
          ip_r    <= ip_r + 64'd1;
        end
        default: trap_r <= trap_r;
      endcase
    end
  end

  // Payload registers: input capture, top-of-stack copy and result word.
  always_ff @(posedge clk) begin
    if (cmd.op == DP_LATCH) begin
      inst_kind_r <= in_inst_kind;
      inst_opnd_r <= $unsigned(in_inst_operand);
    end
    if (exec_ok) begin
      if (kind_rd_r == K_PUSH) top_r <= opnd_rd_r;
      else if (kind_rd_r == K_ADD || kind_rd_r == K_SUB || kind_rd_r == K_EQ) top_r <= alu_res;
      else if (kind_rd_r == K_CJMP && top_r != 64'd0) top_r <= stack_rd_r;
    end
    if (cmd.op == DP_MD_COMMIT) top_r <= md_res;
    if (cmd.op == DP_DUP_COMMIT) top_r <= stack_rd_r;
    if (cmd.op == DP_LOAD_OUT) begin
      out_trap_code    <= trap_r;
      out_next_ip      <= $signed(ip_r);
      out_depth_after  <= 11'(depth_r);
      out_top_word     <= (depth_r != '0) ? $signed(top_r) : 64'sd0;
      out_top_present  <= (depth_r != '0);
      out_is_halted    <= halted_r;
      out_debug_print  <= print_r;
      out_loaded_count <= 11'(len_r);
    end
  end

  assign sts.ip_bad    = ip_bad;
  assign sts.dec_trap  = dec_trap;
  assign sts.dec_class = dec_class;
  assign sts.md_done   = md_done;

endmodule

// ===== src/sms_ctrl.sv =====
// ----------------------------------------------------------------------------
// sms_ctrl
// Sequencer that steps the datapath through append, clear and execute.
// ----------------------------------------------------------------------------
module sms_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_command,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  sms_pkg::dp_status_t  sts,
  output sms_pkg::dp_cmd_t     cmd,
  output sms_pkg::ctrl_state_t state
);
  import sms_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = DP_NOP;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = DP_LATCH;
          case (in_command)
            CMD_APPEND: state_nxt = S_APPEND;
            CMD_EXEC:   state_nxt = S_FETCH;
            CMD_CLEAR:  state_nxt = S_CLEAR;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_APPEND: begin
        cmd.op    = DP_APPEND;
        state_nxt = S_DONE;
      end
      S_CLEAR: begin
        cmd.op    = DP_CLEAR;
        state_nxt = S_DONE;
      end
      S_FETCH: begin
        cmd.op    = DP_FETCH;
        state_nxt = sts.ip_bad ? S_DONE : S_DECODE;
      end
      S_DECODE: begin
        cmd.op = DP_EXEC;
        if (sts.dec_trap != TRAP_OK) begin
          state_nxt = S_DONE;
        end else begin
          case (sts.dec_class)
            CLS_MULDIV: state_nxt = S_MD_WAIT;
            CLS_DUP:    state_nxt = S_DUP_WR;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_MD_WAIT: begin
        if (sts.md_done) begin
          cmd.op    = DP_MD_COMMIT;
          state_nxt = S_DONE;
        end
      end
      S_DUP_WR: begin
        cmd.op    = DP_DUP_COMMIT;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = DP_LOAD_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign state     = state_r;

endmodule

// ===== src/stack_machine_step.sv =====
// ----------------------------------------------------------------------------
// stack_machine_step
// Each transaction steps to its result load: the unused command goes there
// directly, append and clear pass their own state, a bad ip ends at fetch,
// other executes and traps pass fetch and decode, dup adds a write, and
// multiply and divide wait on the shared one-bit-per-cycle unit. The next
// transaction is taken in the cycle after its result is loaded. Reset clears
// control state, depth, program length, ip and the halt flag; the memories are not cleared.
// ----------------------------------------------------------------------------
module stack_machine_step #(
  parameter int STACK_DEPTH   = 1024,
  parameter int PROGRAM_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [3:0]         in_inst_kind,
  input  logic signed [63:0] in_inst_operand,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_trap_code,
  output logic signed [63:0] out_next_ip,
  output logic [10:0]        out_depth_after,
  output logic signed [63:0] out_top_word,
  output logic               out_top_present,
  output logic               out_is_halted,
  output logic               out_debug_print,
  output logic [10:0]        out_loaded_count
);
  import sms_pkg::*;

  // The controller walks each execute through fetch, decode and commit,
  // and the datapath reports check results back as status. A finished result
  // sits in the output register while the block takes the next transaction.
  dp_cmd_t     cmd;
  dp_status_t  sts;
  ctrl_state_t state;

  sms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sts        (sts),
    .cmd        (cmd),
    .state      (state)
  );

  // The datapath holds both memories and the machine registers. A copy of
  // the top word is kept in a register, so results never wait on a read.
  sms_datapath #(
    .STACK_DEPTH   (STACK_DEPTH),
    .PROGRAM_DEPTH (PROGRAM_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_inst_kind     (in_inst_kind),
    .in_inst_operand  (in_inst_operand),
    .out_trap_code    (out_trap_code),
    .out_next_ip      (out_next_ip),
    .out_depth_after  (out_depth_after),
    .out_top_word     (out_top_word),
    .out_top_present  (out_top_present),
    .out_is_halted    (out_is_halted),
    .out_debug_print  (out_debug_print),
    .out_loaded_count (out_loaded_count)
  );

  // A transaction is only taken while the sequencer is idle.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (state == S_IDLE))
    else $error("input accepted while the sequencer is busy");

  // A print only reports when the step did not trap.
  a_print_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_debug_print) |-> (out_trap_code == TRAP_OK))
    else $error("print flag set together with a trap");

  // The top flag agrees with the reported depth.
  a_top_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_top_present == (out_depth_after != 11'd0)))
    else $error("top flag disagrees with depth");

  // Commit from the multiply/divide unit happens only while waiting on it.
  a_md_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_MD_COMMIT) |-> (state == S_MD_WAIT && sts.md_done))
    else $error("multiply/divide commit outside its wait state");

endmodule
